@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared checking macros for the polygon vertex unit, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle (consequent may carry a delay)
`define RPV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define RPV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RPV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/rpv_pkg.sv @@
// ----------------------------------------------------------------------------
// rpv_pkg
// shared types and constants of the regular polygon vertex unit
// ----------------------------------------------------------------------------
package rpv_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 2'd3;

	localparam logic [7:0]  MIN_SIDES   = 8'd3;
	localparam logic [7:0]  HEX_SIDES   = 8'd6;
	localparam logic [7:0]  BASE_K      = 8'd2;
	localparam logic [11:0] MIN_LENGTH  = 12'd1;

	// fixed point
	localparam int TRIG_W = 31;
	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [29:0] HALF_Q30 = 30'h2000_0000;
	localparam int OUT_R_W = 25;
	localparam logic [OUT_R_W-1:0] RAD_MAX = 25'h1FF_FFFF;
	localparam logic [3:0] SIN_TERMS = 4'd8;
	localparam logic [3:0] COS_TERMS = 4'd9;

	// divider
	localparam int DVD_W = 64;
	localparam int DVS_W = 32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [7:0]         n;
	} cfg_t;

	typedef struct packed {
		logic       err;
		logic [1:0] quad;
		logic [7:0] k;
	} item_t;

	typedef struct packed {
		logic [TRIG_W-1:0] s;
		logic [TRIG_W-1:0] c;
	} trig_t;

	// divisor of the j-th taylor term
	function automatic logic [8:0] taylor_div(input logic cos_ph, input logic [3:0] j);
		logic [8:0] d;
		d = 9'd1;
		if (cos_ph) begin
			case (j)
				4'd1: d = 9'd2;
				4'd2: d = 9'd12;
				4'd3: d = 9'd30;
				4'd4: d = 9'd56;
				4'd5: d = 9'd90;
				4'd6: d = 9'd132;
				4'd7: d = 9'd182;
				4'd8: d = 9'd240;
				4'd9: d = 9'd306;
				default: d = 9'd1;
			endcase
		end else begin
			case (j)
				4'd1: d = 9'd6;
				4'd2: d = 9'd20;
				4'd3: d = 9'd42;
				4'd4: d = 9'd72;
				4'd5: d = 9'd110;
				4'd6: d = 9'd156;
				4'd7: d = 9'd210;
				4'd8: d = 9'd272;
				default: d = 9'd1;
			endcase
		end
		return d;
	endfunction

endpackage

@@ src/regular_polygon_vertices_unit.sv @@
// ----------------------------------------------------------------------------
// regular_polygon_vertices_unit
// vertex generator for a regular polygon held in configuration registers
// ----------------------------------------------------------------------------
// Usage:
//  - configuration: cfg_we writes cfg_data to register cfg_index (0 centre x,
//    1 centre y, 2 side count, 3 side length); side count and length are clamped.
//  - a vertex index is transferred at a clock edge with start high and busy low.
//  - each result appears on the result ports for one cycle with done high,
//    after the queue and the back pipeline; the receiver cannot hold it off.
//  - throughput is one index per cycle while busy is low: the back never stalls,
//    a fixed pipeline (table read, sign select, split multiply, round, saturate).
//  - after reset and after a write of side count or side length, busy stays
//    high while the sequencer rebuilds the sin/cos table through its shared
//    multiplier and one-bit-per-cycle divider, one table entry per side, then
//    the radius and apothem.
//  - reset restores centre 0,0, three sides, side length 1 and starts a rebuild.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module regular_polygon_vertices_unit import rpv_pkg::*; #(
	parameter int MAX_SIDES = 180,
	parameter int FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            vertex_index,
	output logic                  done,
	output logic signed [31:0]    vertex_x,
	output logic signed [31:0]    vertex_y,
	output logic [OUT_R_W-1:0]    circumradius,
	output logic [OUT_R_W-1:0]    apothem,
	output logic                  index_error
);

	localparam int RAD_W = FRAC_BITS + 19;
	localparam int KW    = $clog2(MAX_SIDES);
	localparam int LAT   = 6;

	cfg_t             cfg;
	logic             coef_busy;
	logic [RAD_W-1:0] radius;
	logic [RAD_W-1:0] apothem_raw;
	logic             tbl_we;
	logic [KW-1:0]    tbl_addr;
	trig_t            tbl_data;
	logic             push;
	item_t            push_item;
	item_t            head;
	logic             q_empty;
	logic             q_full;
	logic             pop;

	rpv_coef_unit #(
		.MAX_SIDES (MAX_SIDES),
		.FRAC_BITS (FRAC_BITS),
		.RAD_W     (RAD_W),
		.KW        (KW)
	) u_coef (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg         (cfg),
		.busy        (coef_busy),
		.radius      (radius),
		.apothem_raw (apothem_raw),
		.tbl_we      (tbl_we),
		.tbl_addr    (tbl_addr),
		.tbl_data    (tbl_data)
	);

	rpv_front u_front (
		.start        (start),
		.vertex_index (vertex_index),
		.cfg          (cfg),
		.coef_busy    (coef_busy),
		.queue_full   (q_full),
		.busy         (busy),
		.push         (push),
		.item         (push_item)
	);

	rpv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	rpv_back #(
		.MAX_SIDES (MAX_SIDES),
		.FRAC_BITS (FRAC_BITS),
		.RAD_W     (RAD_W),
		.KW        (KW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tbl_we       (tbl_we),
		.tbl_addr     (tbl_addr),
		.tbl_data     (tbl_data),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.cfg          (cfg),
		.radius       (radius),
		.apothem_raw  (apothem_raw),
		.done         (done),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.circumradius (circumradius),
		.apothem      (apothem),
		.index_error  (index_error)
	);

	// every transfer yields its result with done high
	`RPV_ASSERT_IMP(a_fixed_latency, clk, arst_n, start && !busy, ##LAT done)

endmodule

@@ src/rpv_divider.sv @@
// ----------------------------------------------------------------------------
// rpv_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rpv_divider import rpv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             active_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic             fits;
	logic [DVS_W:0]   rem_nx;

	// one shift and subtract step
	always_comb begin
		rem_sh = {rem_q[DVS_W-1:0], dq_q[DVD_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
		rem_nx = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (active_q) begin
			rem_q <= rem_nx;
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ src/rpv_coef_unit.sv @@
// ----------------------------------------------------------------------------
// rpv_coef_unit
// configuration registers and the sequencer that builds the trig table,
// circumradius and apothem after reset and after a shape change
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpv_coef_unit import rpv_pkg::*; #(
	parameter int MAX_SIDES = 180,
	parameter int FRAC_BITS = 8,
	parameter int RAD_W     = 27,
	parameter int KW        = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic                  busy,
	output logic [RAD_W-1:0]      radius,
	output logic [RAD_W-1:0]      apothem_raw,
	output logic                  tbl_we,
	output logic [KW-1:0]         tbl_addr,
	output trig_t                 tbl_data
);

	localparam int MA    = (RAD_W > 32) ? RAD_W : 32;
	localparam int ACC_W = MA + 32;
	localparam int SUM_W = 35;
	localparam int KPI_W = 40;

	typedef enum logic [16:0] {
		ST_IDLE     = 17'h00001,
		ST_ANG_MUL  = 17'h00002,
		ST_ANG_DIV  = 17'h00004,
		ST_ANG_WAIT = 17'h00008,
		ST_SQ_LO    = 17'h00010,
		ST_SQ_HI    = 17'h00020,
		ST_TRM_INIT = 17'h00040,
		ST_TRM_LO   = 17'h00080,
		ST_TRM_HI   = 17'h00100,
		ST_TRM_DIV  = 17'h00200,
		ST_TRM_WAIT = 17'h00400,
		ST_STORE    = 17'h00800,
		ST_RAD_DIV  = 17'h01000,
		ST_RAD_WAIT = 17'h02000,
		ST_APO_LO   = 17'h04000,
		ST_APO_HI   = 17'h08000,
		ST_APO_FIN  = 17'h10000
	} state_t;

	state_t state_q;

	logic signed [15:0] cx_q;
	logic signed [15:0] cy_q;
	logic [7:0]         n_q;
	logic [11:0]        len_q;
	logic               pending_q;
	logic [7:0]         side_v;
	logic [11:0]        len_v;

	logic [7:0]              k_q;
	logic [KPI_W-1:0]        kpi_q;
	logic [TRIG_W-1:0]       x_q;
	logic [31:0]             x2_q;
	logic [31:0]             term_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nx;
	logic [3:0]              j_q;
	logic                    cos_ph_q;
	logic [TRIG_W-1:0]       sin_q;
	logic [TRIG_W-1:0]       cos_q;
	logic [TRIG_W-1:0]       sb_q;
	logic [TRIG_W-1:0]       cb_q;
	logic [RAD_W-1:0]        radius_q;
	logic [RAD_W-1:0]        apo_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    last_term;

	logic [MA-1:0]      mul_a;
	logic [31:0]        mul_b;
	logic [15:0]        mul_half;
	logic [MA+15:0]     prod;
	logic               mul_lo;
	logic               mul_hi;

	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic               div_done;
	logic [DVD_W-1:0]   div_q;

	function automatic logic [TRIG_W-1:0] clamp_unit(input logic signed [SUM_W-1:0] v);
		logic [TRIG_W-1:0] r;
		if (v[SUM_W-1])
			r = '0;
		else if (v > SUM_W'(Q30_ONE))
			r = Q30_ONE;
		else
			r = v[TRIG_W-1:0];
		return r;
	endfunction

	// clamped register values
	always_comb begin
		side_v = cfg_data[7:0];
		if (side_v < MIN_SIDES)
			side_v = MIN_SIDES;
		else if (side_v > 8'(MAX_SIDES))
			side_v = 8'(MAX_SIDES);
		len_v = cfg_data[11:0];
		if (len_v < MIN_LENGTH)
			len_v = MIN_LENGTH;
	end

	// configuration registers, a shape change asks for a rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q      <= '0;
			cy_q      <= '0;
			n_q       <= MIN_SIDES;
			len_q     <= MIN_LENGTH;
			pending_q <= 1'b1;
		end else begin
			if (state_q == ST_IDLE && pending_q)
				pending_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CENTER_X:    cx_q <= $signed(cfg_data);
					REG_CENTER_Y:    cy_q <= $signed(cfg_data);
					REG_SIDE_COUNT: begin
						n_q       <= side_v;
						pending_q <= 1'b1;
					end
					REG_SIDE_LENGTH: begin
						len_q     <= len_v;
						pending_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// shared multiplier, two half-word passes
	always_comb begin
		mul_lo = (state_q == ST_SQ_LO) || (state_q == ST_TRM_LO) || (state_q == ST_APO_LO);
		mul_hi = (state_q == ST_SQ_HI) || (state_q == ST_TRM_HI) || (state_q == ST_APO_HI);
		mul_a  = MA'(term_q);
		mul_b  = x2_q;
		if (state_q == ST_SQ_LO || state_q == ST_SQ_HI) begin
			mul_a = MA'(x_q);
			mul_b = 32'(x_q);
		end else if (state_q == ST_APO_LO || state_q == ST_APO_HI) begin
			mul_a = MA'(radius_q);
			mul_b = 32'(cb_q);
		end
		mul_half = mul_hi ? mul_b[31:16] : mul_b[15:0];
		prod     = mul_a * mul_half;
	end

	// divider operands
	always_comb begin
		div_start = (state_q == ST_ANG_DIV) || (state_q == ST_TRM_DIV) ||
			(state_q == ST_RAD_DIV);
		div_dvd = 64'(kpi_q) + 64'(n_q);
		div_dvs = 32'({n_q, 1'b0});
		if (state_q == ST_TRM_DIV) begin
			div_dvd = 64'(acc_q >> 30);
			div_dvs = 32'(taylor_div(cos_ph_q, j_q));
		end else if (state_q == ST_RAD_DIV) begin
			div_dvd = (64'(len_q[11:1]) << (30 + FRAC_BITS)) + 64'(sb_q >> 1);
			div_dvs = 32'(sb_q);
		end
	end

	rpv_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	// taylor step
	always_comb begin
		sum_nx    = j_q[0] ? sum_q - $signed(SUM_W'(div_q[31:0]))
			: sum_q + $signed(SUM_W'(div_q[31:0]));
		last_term = cos_ph_q ? (j_q == COS_TERMS) : (j_q == SIN_TERMS);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:     if (pending_q) state_q <= ST_ANG_MUL;
				ST_ANG_MUL:  state_q <= ST_ANG_DIV;
				ST_ANG_DIV:  state_q <= ST_ANG_WAIT;
				ST_ANG_WAIT: if (div_done) state_q <= ST_SQ_LO;
				ST_SQ_LO:    state_q <= ST_SQ_HI;
				ST_SQ_HI:    state_q <= ST_TRM_INIT;
				ST_TRM_INIT: state_q <= ST_TRM_LO;
				ST_TRM_LO:   state_q <= ST_TRM_HI;
				ST_TRM_HI:   state_q <= ST_TRM_DIV;
				ST_TRM_DIV:  state_q <= ST_TRM_WAIT;
				ST_TRM_WAIT: begin
					if (div_done)
						state_q <= (last_term && cos_ph_q) ? ST_STORE : ST_TRM_LO;
				end
				ST_STORE:    state_q <= (k_q >= n_q - 8'd1) ? ST_RAD_DIV : ST_ANG_MUL;
				ST_RAD_DIV:  state_q <= ST_RAD_WAIT;
				ST_RAD_WAIT: if (div_done) state_q <= ST_APO_LO;
				ST_APO_LO:   state_q <= ST_APO_HI;
				ST_APO_HI:   state_q <= ST_APO_FIN;
				ST_APO_FIN:  state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (mul_lo)
			acc_q <= ACC_W'(prod);
		else if (mul_hi)
			acc_q <= acc_q + (ACC_W'(prod) << 16);

		case (state_q)
			ST_IDLE:    k_q <= '0;
			ST_ANG_MUL: kpi_q <= KPI_W'(k_q) * KPI_W'(PI_Q30);
			ST_ANG_WAIT: if (div_done) x_q <= div_q[TRIG_W-1:0];
			ST_TRM_INIT: begin
				x2_q     <= 32'(acc_q >> 30);
				term_q   <= 32'(x_q);
				sum_q    <= SUM_W'(x_q);
				j_q      <= 4'd1;
				cos_ph_q <= 1'b0;
			end
			ST_TRM_WAIT: begin
				if (div_done) begin
					if (last_term && !cos_ph_q) begin
						sin_q    <= clamp_unit(sum_nx);
						cos_ph_q <= 1'b1;
						term_q   <= 32'(Q30_ONE);
						sum_q    <= SUM_W'(Q30_ONE);
						j_q      <= 4'd1;
					end else if (last_term) begin
						cos_q <= clamp_unit(sum_nx);
					end else begin
						term_q <= div_q[31:0];
						sum_q  <= sum_nx;
						j_q    <= j_q + 4'd1;
					end
				end
			end
			ST_STORE: begin
				if (k_q == BASE_K) begin
					sb_q <= sin_q;
					cb_q <= cos_q;
				end
				k_q <= k_q + 8'd1;
			end
			ST_RAD_WAIT: if (div_done) radius_q <= div_q[RAD_W-1:0];
			ST_APO_FIN:  apo_q <= RAD_W'((acc_q + ACC_W'(HALF_Q30)) >> 30);
			default: ;
		endcase
	end

	assign tbl_we      = (state_q == ST_STORE);
	assign tbl_addr    = k_q[KW-1:0];
	assign tbl_data    = '{s: sin_q, c: cos_q};
	assign busy        = pending_q || (state_q != ST_IDLE);
	assign radius      = radius_q;
	assign apothem_raw = apo_q;
	assign cfg         = '{cx: cx_q, cy: cy_q, n: n_q};

	// divider results only arrive while the sequencer waits for them
	`RPV_ASSERT_IMP(a_div_done_waiting, clk, arst_n, div_done,
		(state_q == ST_ANG_WAIT || state_q == ST_TRM_WAIT || state_q == ST_RAD_WAIT))
	// a table write always leads on to the next angle or the radius
	`RPV_ASSERT_NXT(a_store_next, clk, arst_n, state_q == ST_STORE,
		(state_q == ST_ANG_MUL || state_q == ST_RAD_DIV))

endmodule

@@ src/rpv_front.sv @@
// ----------------------------------------------------------------------------
// rpv_front
// accepts vertex indices, checks the range and reduces to quadrant and step
// ----------------------------------------------------------------------------
module rpv_front import rpv_pkg::*; (
	input  logic       start,
	input  logic [7:0] vertex_index,
	input  cfg_t       cfg,
	input  logic       coef_busy,
	input  logic       queue_full,
	output logic       busy,
	output logic       push,
	output item_t      item
);

	logic [9:0] u;
	logic [9:0] n1;
	logic [9:0] n2;
	logic [9:0] n3;

	// quadrant and remainder of 4*i over n
	always_comb begin
		u  = {vertex_index, 2'b00};
		n1 = 10'(cfg.n);
		n2 = {1'b0, cfg.n, 1'b0};
		n3 = n1 + n2;
		item.err = vertex_index >= cfg.n;
		if (u >= n3) begin
			item.quad = 2'd3;
			item.k    = 8'(u - n3);
		end else if (u >= n2) begin
			item.quad = 2'd2;
			item.k    = 8'(u - n2);
		end else if (u >= n1) begin
			item.quad = 2'd1;
			item.k    = 8'(u - n1);
		end else begin
			item.quad = 2'd0;
			item.k    = u[7:0];
		end
	end

	assign busy = coef_busy || queue_full;
	assign push = start && !busy;

endmodule

@@ src/rpv_queue.sv @@
// ----------------------------------------------------------------------------
// rpv_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpv_queue import rpv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_pop;

	assign do_pop = pop && !empty;

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));

	// the front only transfers into a queue with room
	`RPV_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full)

endmodule

@@ src/rpv_back.sv @@
// ----------------------------------------------------------------------------
// rpv_back
// trig table, quadrant signs, radius scaling and output registers
// ----------------------------------------------------------------------------
module rpv_back import rpv_pkg::*; #(
	parameter int MAX_SIDES = 180,
	parameter int FRAC_BITS = 8,
	parameter int RAD_W     = 27,
	parameter int KW        = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tbl_we,
	input  logic [KW-1:0]       tbl_addr,
	input  trig_t               tbl_data,
	input  item_t               head,
	input  logic                empty,
	output logic                pop,
	input  cfg_t                cfg,
	input  logic [RAD_W-1:0]    radius,
	input  logic [RAD_W-1:0]    apothem_raw,
	output logic                done,
	output logic signed [31:0]  vertex_x,
	output logic signed [31:0]  vertex_y,
	output logic [OUT_R_W-1:0]  circumradius,
	output logic [OUT_R_W-1:0]  apothem,
	output logic                index_error
);

	localparam int PRD_W = RAD_W + TRIG_W;
	localparam int PW    = RAD_W + 3;
	localparam int CW    = (RAD_W > OUT_R_W) ? RAD_W : OUT_R_W;

	trig_t tbl_q [MAX_SIDES];

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              err_s1, err_s2, err_s3, err_s4;
	logic [1:0]        quad_s1;
	trig_t             rd_s1;
	logic              negx_s2, negy_s2, negx_s3, negy_s3, negx_s4, negy_s4;
	logic [TRIG_W-1:0] magx_s2, magy_s2;
	logic [RAD_W+15:0] plox_s3, ploy_s3;
	logic [RAD_W+15:0] phix_s3, phiy_s3;
	logic [RAD_W-1:0]  offx_s4, offy_s4;
	logic              done_q;
	logic signed [31:0] vx_q, vy_q;
	logic [OUT_R_W-1:0] rad_q, apo_q;
	logic               err_q;

	logic              sa_neg, ca_neg;
	logic [TRIG_W-1:0] sa_mag, ca_mag;
	logic [PRD_W-1:0]  fullx, fully;
	logic signed [PW-1:0] cxs, cys, offxs, offys, pxw, pyw;

	// compared at 64 bits so that the limits are never cut down
	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [31:0] r;
		if (64'(v) > 64'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (64'(v) < -64'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = 32'(v);
		return r;
	endfunction

	function automatic logic [OUT_R_W-1:0] sat_r(input logic [RAD_W-1:0] v);
		logic [OUT_R_W-1:0] r;
		if (CW'(v) > CW'(RAD_MAX))
			r = RAD_MAX;
		else
			r = OUT_R_W'(v);
		return r;
	endfunction

	assign pop = !empty;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_q[tbl_addr] <= tbl_data;
		if (pop)
			rd_s1 <= tbl_q[head.k[KW-1:0]];
		err_s1  <= head.err;
		quad_s1 <= head.quad;
	end

	// quadrant signs and hexagon swap
	always_comb begin
		case (quad_s1)
			2'd0: begin
				sa_mag = rd_s1.s; sa_neg = 1'b0; ca_mag = rd_s1.c; ca_neg = 1'b0;
			end
			2'd1: begin
				sa_mag = rd_s1.c; sa_neg = 1'b0; ca_mag = rd_s1.s; ca_neg = 1'b1;
			end
			2'd2: begin
				sa_mag = rd_s1.s; sa_neg = 1'b1; ca_mag = rd_s1.c; ca_neg = 1'b1;
			end
			default: begin
				sa_mag = rd_s1.c; sa_neg = 1'b1; ca_mag = rd_s1.s; ca_neg = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cfg.n == HEX_SIDES) begin
			magx_s2 <= ca_mag; negx_s2 <= ca_neg;
			magy_s2 <= sa_mag; negy_s2 <= sa_neg;
		end else begin
			magx_s2 <= sa_mag; negx_s2 <= sa_neg;
			magy_s2 <= ca_mag; negy_s2 <= ca_neg;
		end
		err_s2 <= err_s1;
	end

	// partial products of radius and trig magnitude
	always_ff @(posedge clk) begin
		plox_s3 <= radius * magx_s2[15:0];
		phix_s3 <= radius * magx_s2[TRIG_W-1:16];
		ploy_s3 <= radius * magy_s2[15:0];
		phiy_s3 <= radius * magy_s2[TRIG_W-1:16];
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		err_s3  <= err_s2;
	end

	// recombine and round
	always_comb begin
		fullx = PRD_W'(plox_s3) + (PRD_W'(phix_s3) << 16) + PRD_W'(HALF_Q30);
		fully = PRD_W'(ploy_s3) + (PRD_W'(phiy_s3) << 16) + PRD_W'(HALF_Q30);
	end

	always_ff @(posedge clk) begin
		offx_s4 <= RAD_W'(fullx >> 30);
		offy_s4 <= RAD_W'(fully >> 30);
		negx_s4 <= negx_s3;
		negy_s4 <= negy_s3;
		err_s4  <= err_s3;
	end

	// centre minus offset, saturated
	always_comb begin
		cxs   = PW'(cfg.cx) <<< FRAC_BITS;
		cys   = PW'(cfg.cy) <<< FRAC_BITS;
		offxs = $signed(PW'(offx_s4));
		offys = $signed(PW'(offy_s4));
		pxw   = negx_s4 ? cxs + offxs : cxs - offxs;
		pyw   = negy_s4 ? cys + offys : cys - offys;
	end

	always_ff @(posedge clk) begin
		vx_q  <= err_s4 ? 32'sd0 : sat32(pxw);
		vy_q  <= err_s4 ? 32'sd0 : sat32(pyw);
		err_q <= err_s4;
		rad_q <= sat_r(radius);
		apo_q <= sat_r(apothem_raw);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= pop;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	assign done         = done_q;
	assign vertex_x     = vx_q;
	assign vertex_y     = vy_q;
	assign circumradius = rad_q;
	assign apothem      = apo_q;
	assign index_error  = err_q;

endmodule

@@ tb/regular_polygon_vertices_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regular_polygon_vertices_unit_test
// runs the vertex unit through a series of polygon settings, predicts every
// vertex, radius and apothem in fixed point and checks each result in order
// ----------------------------------------------------------------------------
module regular_polygon_vertices_unit_test;
	import rpv_pkg::*;

	localparam int FRAC = 8;
	localparam int NMAX = 180;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam longint unsigned PI_VAL = 64'd3373259426;
	localparam longint unsigned RSAT = 64'd33554431;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [24:0]        rad;
		logic [24:0]        apo;
		logic               err;
	} vertex_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic [7:0]            vertex_index;
	logic                  done;
	logic signed [31:0]    vertex_x;
	logic signed [31:0]    vertex_y;
	logic [OUT_R_W-1:0]    circumradius;
	logic [OUT_R_W-1:0]    apothem;
	logic                  index_error;

	// polygon settings as the block should hold them
	int signed   pg_cx;
	int signed   pg_cy;
	int unsigned pg_n;
	int unsigned pg_len;

	logic [7:0] pending_idx[$];
	vertex_t    expected_vertices[$];
	int         idle_pct;
	int         fail_count;

	regular_polygon_vertices_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .vertex_index(vertex_index),
		.done(done), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.circumradius(circumradius), .apothem(apothem), .index_error(index_error)
	);

	// angle k*pi/(2n) in q2.30, rounded
	function automatic longint unsigned angle_of(longint unsigned k, longint unsigned n);
		return (k * PI_VAL + n) / (2 * n);
	endfunction

	function automatic longint signed unit_clamp(longint signed v);
		if (v < 0) return 0;
		if (v > longint'(ONE_Q30)) return longint'(ONE_Q30);
		return v;
	endfunction

	// taylor series, each product truncated
	function automatic longint signed sine_q30(longint unsigned x);
		longint unsigned x2, term, j;
		longint signed sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (j = 1; j <= 8; j++) begin
			term = ((term * x2) >> 30) / ((2 * j) * (2 * j + 1));
			if (j[0]) sum -= longint'(term); else sum += longint'(term);
		end
		return unit_clamp(sum);
	endfunction

	function automatic longint signed cosine_q30(longint unsigned x);
		longint unsigned x2, term, j;
		longint signed sum;
		x2 = (x * x) >> 30;
		term = ONE_Q30;
		sum = longint'(ONE_Q30);
		for (j = 1; j <= 9; j++) begin
			term = ((term * x2) >> 30) / ((2 * j - 1) * (2 * j));
			if (j[0]) sum -= longint'(term); else sum += longint'(term);
		end
		return unit_clamp(sum);
	endfunction

	// round(r*v/2^30) half away from zero
	function automatic longint signed offset_of(longint unsigned r, longint signed v);
		longint unsigned mag, p;
		mag = (v < 0) ? longint'(-v) : v;
		p = (r * mag + (ONE_Q30 >> 1)) >> 30;
		return (v < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic [31:0] sat_coord(longint signed v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic vertex_t vertex_for(logic [7:0] idx);
		vertex_t r;
		longint unsigned n, half, base, radius, apo, u, q, k, th;
		longint signed sb, cb, s0, c0, sa, ca, tx, ty;
		n = pg_n;
		half = pg_len / 2;
		base = angle_of(2, n);
		sb = sine_q30(base);
		cb = cosine_q30(base);
		radius = ((half << (30 + FRAC)) + (longint'(sb) >> 1)) / sb;
		apo = (radius * cb + (ONE_Q30 >> 1)) >> 30;
		r.rad = (radius > RSAT) ? RSAT[24:0] : radius[24:0];
		r.apo = (apo > RSAT) ? RSAT[24:0] : apo[24:0];
		if (idx >= n) begin
			r.x = '0;
			r.y = '0;
			r.err = 1'b1;
		end else begin
			u = (4 * idx) % (4 * n);
			q = u / n;
			k = u % n;
			th = angle_of(k, n);
			s0 = sine_q30(th);
			c0 = cosine_q30(th);
			case (q[1:0])
				2'd0: begin sa = s0; ca = c0; end
				2'd1: begin sa = c0; ca = -s0; end
				2'd2: begin sa = -s0; ca = -c0; end
				default: begin sa = -c0; ca = s0; end
			endcase
			// hexagons lie flat
			if (n == HEX_SIDES) begin tx = ca; ty = sa; end else begin tx = sa; ty = ca; end
			r.x = sat_coord(longint'(pg_cx) * (64'sd1 << FRAC) - offset_of(radius, tx));
			r.y = sat_coord(longint'(pg_cy) * (64'sd1 << FRAC) - offset_of(radius, ty));
			r.err = 1'b0;
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: present pending indices, hold while busy
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			vertex_index <= '0;
		end else begin
			if (start && !busy)
				expected_vertices = {expected_vertices, vertex_for(vertex_index)};
			if (!start || !busy) begin
				if (pending_idx.size() > 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					vertex_index <= pending_idx.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: one result per strobe against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_vertices.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				vertex_t e;
				e = expected_vertices.pop_front();
				if (vertex_x !== e.x) begin
					$error("vertex_x expected %0d got %0d", e.x, vertex_x); fail_count++;
				end
				if (vertex_y !== e.y) begin
					$error("vertex_y expected %0d got %0d", e.y, vertex_y); fail_count++;
				end
				if (circumradius !== e.rad) begin
					$error("circumradius expected %0d got %0d", e.rad, circumradius);
					fail_count++;
				end
				if (apothem !== e.apo) begin
					$error("apothem expected %0d got %0d", e.apo, apothem); fail_count++;
				end
				if (index_error !== e.err) begin
					$error("index_error expected %0d got %0d", e.err, index_error);
					fail_count++;
				end
			end
		end
	end

	// register write, then wait out any table rebuild
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		int unsigned v;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_X: pg_cx = $signed(data);
			REG_CENTER_Y: pg_cy = $signed(data);
			REG_SIDE_COUNT: begin
				v = data[7:0];
				if (v < MIN_SIDES) v = MIN_SIDES;
				if (v > NMAX) v = NMAX;
				pg_n = v;
			end
			default: begin
				v = data[11:0];
				if (v < MIN_LENGTH) v = MIN_LENGTH;
				pg_len = v;
			end
		endcase
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// queue a set of indices and wait until every result is back
	task automatic run_items(int count, int pct);
		int j;
		idle_pct = pct;
		pending_idx = {pending_idx, 8'd0};
		pending_idx = {pending_idx, 8'(pg_n - 1)};
		pending_idx = {pending_idx, pg_n[7:0]};
		pending_idx = {pending_idx, 8'd255};
		for (j = 0; j < count; j++) begin
			if ($urandom_range(99) < 85)
				pending_idx = {pending_idx, 8'($urandom_range(pg_n - 1))};
			else
				pending_idx = {pending_idx, 8'($urandom_range(255))};
		end
		@(posedge clk);
		while (pending_idx.size() > 0 || start || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// run sequence
	initial begin
		int p;
		int pcts[4];
		pcts = '{0, 47, 0, 17};
		fail_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data = '0;
		idle_pct = 0;
		pg_cx = 0; pg_cy = 0; pg_n = 3; pg_len = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// reset settings, then extremes and clamped writes
		run_items(8, 0);
		write_reg(REG_CENTER_X, 16'h7FFF);
		write_reg(REG_CENTER_Y, 16'h8000);
		write_reg(REG_SIDE_LENGTH, 16'h0FFF);
		write_reg(REG_SIDE_COUNT, 16'h0000);
		run_items(10, 47);
		write_reg(REG_CENTER_X, 16'h8000);
		write_reg(REG_CENTER_Y, 16'h7FFF);
		write_reg(REG_SIDE_LENGTH, 16'd2000);
		write_reg(REG_SIDE_COUNT, 16'd6);
		run_items(10, 0);
		write_reg(REG_SIDE_LENGTH, 16'hF000);
		write_reg(REG_SIDE_COUNT, 16'h0101);
		run_items(10, 17);

		// random polygons of modest size
		for (p = 0; p < 8; p++) begin
			write_reg(REG_CENTER_X, 16'($urandom));
			write_reg(REG_CENTER_Y, 16'($urandom));
			write_reg(REG_SIDE_LENGTH, 16'($urandom));
			write_reg(REG_SIDE_COUNT, (p == 1) ? 16'd6 : 16'($urandom_range(24, 3)));
			run_items(100, pcts[p % 4]);
		end

		// the largest polygon once
		write_reg(REG_SIDE_LENGTH, 16'hFFFF);
		write_reg(REG_SIDE_COUNT, 16'h00FF);
		run_items(200, 17);

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#60_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/rpv_pkg.sv
src/rpv_divider.sv
src/rpv_coef_unit.sv
src/rpv_front.sv
src/rpv_queue.sv
src/rpv_back.sv
src/regular_polygon_vertices_unit.sv
tb/regular_polygon_vertices_unit_test.sv
